>>> hw/rtl/kdd_pkg.sv
// Package for the keypad differential drive command block.
// Holds key codes, key classes, the impulse entry type and shared widths.
// No dependencies.
`default_nettype none

package kdd_pkg;

    // Fixed widths of the fields and registers
    localparam int AGE_W      = 21;
    localparam int ELAPSED_W  = 20;
    localparam int KEY_W      = 8;
    localparam int LIMIT_W    = 16;
    localparam int TURN_W     = 12;
    localparam int INC_W      = 16;
    localparam int SPEED_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Default ring depth
    localparam int NUM_IMPULSES_DEF = 16;

    // Register reset values and limits
    localparam logic [LIMIT_W-1:0]   SPEED_LIMIT_RST = 16'd50000;
    localparam logic [TURN_W-1:0]    TURN_STEP_RST   = 12'd1000;
    localparam logic [AGE_W-1:0]     LIFETIME_RST    = 21'd1000000;
    localparam logic signed [INC_W-1:0] INC_RST      = 16'sd10;
    localparam logic signed [INC_W-1:0] INC_MAX      = 16'sd32767;
    localparam logic signed [INC_W-1:0] INC_MIN      = -16'sd32767;
    localparam int                   OUT_MAX         = 131071;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 2'd2;

    // ASCII key codes
    localparam logic [KEY_W-1:0] KEY_CODE_NONE   = 8'h00;
    localparam logic [KEY_W-1:0] KEY_CODE_S      = 8'h73;
    localparam logic [KEY_W-1:0] KEY_CODE_5      = 8'h35;
    localparam logic [KEY_W-1:0] KEY_CODE_W      = 8'h77;
    localparam logic [KEY_W-1:0] KEY_CODE_8      = 8'h38;
    localparam logic [KEY_W-1:0] KEY_CODE_X      = 8'h78;
    localparam logic [KEY_W-1:0] KEY_CODE_2      = 8'h32;
    localparam logic [KEY_W-1:0] KEY_CODE_A      = 8'h61;
    localparam logic [KEY_W-1:0] KEY_CODE_4      = 8'h34;
    localparam logic [KEY_W-1:0] KEY_CODE_D      = 8'h64;
    localparam logic [KEY_W-1:0] KEY_CODE_6      = 8'h36;
    localparam logic [KEY_W-1:0] KEY_CODE_PLUS   = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_CODE_MINUS  = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_CODE_Q      = 8'h71;
    localparam logic [KEY_W-1:0] KEY_CODE_7      = 8'h37;
    localparam logic [KEY_W-1:0] KEY_CODE_Y      = 8'h79;
    localparam logic [KEY_W-1:0] KEY_CODE_1      = 8'h31;
    localparam logic [KEY_W-1:0] KEY_CODE_E      = 8'h65;
    localparam logic [KEY_W-1:0] KEY_CODE_9      = 8'h39;
    localparam logic [KEY_W-1:0] KEY_CODE_C      = 8'h63;
    localparam logic [KEY_W-1:0] KEY_CODE_3      = 8'h33;

    // Decoded key classes
    typedef enum logic [3:0] {
        KEY_IDLE,
        KEY_STOP,
        KEY_FWD,
        KEY_BACK,
        KEY_LEFT,
        KEY_RIGHT,
        KEY_INC,
        KEY_DEC,
        KEY_BAD
    } key_class_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_MUL,
        ST_SUM
    } state_t;

    // One turn impulse entry
    typedef struct packed {
        logic             active;
        logic             right;
        logic [AGE_W-1:0] age;
    } impulse_t;

    // Per-entry controls handed to the ring head
    typedef struct packed {
        logic stop;
        logic push;
        logic push_right;
        logic at_slot;
    } head_ctrl_t;

    // Map an ASCII code onto a key class
    function automatic key_class_t decode_key(input logic [KEY_W-1:0] code);
        key_class_t k;
        case (code)
            KEY_CODE_S, KEY_CODE_5:          k = KEY_STOP;
            KEY_CODE_W, KEY_CODE_8:          k = KEY_FWD;
            KEY_CODE_X, KEY_CODE_2:          k = KEY_BACK;
            KEY_CODE_A, KEY_CODE_4:          k = KEY_LEFT;
            KEY_CODE_D, KEY_CODE_6:          k = KEY_RIGHT;
            KEY_CODE_PLUS:                   k = KEY_INC;
            KEY_CODE_MINUS:                  k = KEY_DEC;
            KEY_CODE_Q, KEY_CODE_7, KEY_CODE_Y, KEY_CODE_1,
            KEY_CODE_E, KEY_CODE_9, KEY_CODE_C, KEY_CODE_3,
            KEY_CODE_NONE:                   k = KEY_IDLE;
            default:                         k = KEY_BAD;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/keypad_differential_drive_command.sv
// Keypad differential drive command: top level with controller, speed
// state, impulse ring of kdd_cell instances around one kdd_head, and output.
// Depends on kdd_pkg, kdd_cell and kdd_head.
`default_nettype none

// Each accepted key item updates the base speed and step at once, then the
// turn impulse ring makes one full rotation, one entry per cycle through the
// shared head, which ages, expires, clears or writes the entry before it is
// counted. A multiply state and a sum-and-clamp state follow, after which the
// block is ready for the next item. The result sits in an output register, so
// a new item is taken while the previous result waits for its transfer; the
// sum stage holds only if that register is still full. Configuration writes
// are always taken and land in the registers in the next cycle.
module keypad_differential_drive_command #(
    parameter int NUM_IMPULSES = kdd_pkg::NUM_IMPULSES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kdd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kdd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [kdd_pkg::KEY_W-1:0]         operation,
    input  wire logic [kdd_pkg::ELAPSED_W-1:0]     elapsed,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [kdd_pkg::SPEED_W-1:0]     left_speed,
    output logic signed [kdd_pkg::SPEED_W-1:0]     right_speed,
    output logic                                   unknown_key
);

    localparam int IW = (NUM_IMPULSES > 1) ? $clog2(NUM_IMPULSES) : 1;
    localparam int CW = $clog2(NUM_IMPULSES + 1) + 1;
    localparam int DW = CW + kdd_pkg::TURN_W + 1;
    localparam int SW = (DW + 1 > kdd_pkg::SPEED_W + 1) ? DW + 1 : kdd_pkg::SPEED_W + 1;
    localparam int BW = kdd_pkg::SPEED_W + 1;

    // Configuration registers
    logic [kdd_pkg::LIMIT_W-1:0] speed_limit_reg;
    logic [kdd_pkg::TURN_W-1:0]  turn_step_reg;
    logic [kdd_pkg::AGE_W-1:0]   lifetime_reg;

    // Block state
    kdd_pkg::state_t                   state_reg, state_next;
    logic signed [kdd_pkg::SPEED_W-1:0] base_speed_reg;
    logic signed [kdd_pkg::INC_W-1:0]   speed_inc_reg;
    logic [IW-1:0]                     write_slot_reg;
    logic [IW-1:0]                     step_reg;
    kdd_pkg::key_class_t               kcls_reg;
    logic [kdd_pkg::ELAPSED_W-1:0]     elapsed_reg;
    logic signed [CW-1:0]              count_reg;
    logic signed [DW-1:0]              dir_reg;

    // Output register
    logic                              out_valid_reg;
    logic signed [kdd_pkg::SPEED_W-1:0] left_reg;
    logic signed [kdd_pkg::SPEED_W-1:0] right_reg;
    logic                              unknown_reg;

    // Handshake and decode
    logic                in_xfer;
    logic                shift;
    logic                last_step;
    logic                sum_load;
    kdd_pkg::key_class_t kcls_in;

    // Speed arithmetic
    logic signed [BW-1:0] lim_pos;
    logic signed [BW-1:0] lim_neg;
    logic signed [BW-1:0] speed_sum;
    logic signed [BW-1:0] speed_clamped;
    logic signed [SW-1:0] left_sum;
    logic signed [SW-1:0] right_sum;
    logic signed [SW-1:0] out_max;
    logic signed [SW-1:0] out_min;
    logic signed [kdd_pkg::SPEED_W-1:0] left_sat;
    logic signed [kdd_pkg::SPEED_W-1:0] right_sat;

    // Ring
    kdd_pkg::impulse_t   cell_q [NUM_IMPULSES];
    kdd_pkg::impulse_t   head_out;
    kdd_pkg::head_ctrl_t head_ctrl;
    logic [IW-1:0]       cur_slot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == kdd_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign kcls_in   = kdd_pkg::decode_key(operation);
    assign shift     = (state_reg == kdd_pkg::ST_SWEEP);
    assign last_step = (step_reg == IW'(NUM_IMPULSES - 1));
    assign sum_load  = (state_reg == kdd_pkg::ST_SUM) && (!out_valid_reg || out_ready);

    // Write configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= kdd_pkg::SPEED_LIMIT_RST;
            turn_step_reg   <= kdd_pkg::TURN_STEP_RST;
            lifetime_reg    <= kdd_pkg::LIFETIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kdd_pkg::CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[kdd_pkg::LIMIT_W-1:0];
                kdd_pkg::CFG_TURN_STEP:   turn_step_reg   <= cfg_data[kdd_pkg::TURN_W-1:0];
                kdd_pkg::CFG_LIFETIME:    lifetime_reg    <= cfg_data[kdd_pkg::AGE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Base speed step and clamp
    always_comb
    begin
        lim_pos   = $signed({{(BW - kdd_pkg::LIMIT_W){1'b0}}, speed_limit_reg});
        lim_neg   = -lim_pos;
        speed_sum = BW'(base_speed_reg);
        if (kcls_in == kdd_pkg::KEY_FWD)
        begin
            speed_sum = BW'(base_speed_reg) + BW'(speed_inc_reg);
        end
        else if (kcls_in == kdd_pkg::KEY_BACK)
        begin
            speed_sum = BW'(base_speed_reg) - BW'(speed_inc_reg);
        end
        if (speed_sum > lim_pos)
        begin
            speed_clamped = lim_pos;
        end
        else if (speed_sum < lim_neg)
        begin
            speed_clamped = lim_neg;
        end
        else
        begin
            speed_clamped = speed_sum;
        end
    end

    // Latch the key and act on speed, step and stop at transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg <= '0;
            speed_inc_reg  <= kdd_pkg::INC_RST;
            kcls_reg       <= kdd_pkg::KEY_IDLE;
            elapsed_reg    <= '0;
        end
        else if (in_xfer)
        begin
            kcls_reg    <= kcls_in;
            elapsed_reg <= elapsed;
            case (kcls_in)
                kdd_pkg::KEY_STOP:
                begin
                    base_speed_reg <= '0;
                end
                kdd_pkg::KEY_FWD, kdd_pkg::KEY_BACK:
                begin
                    base_speed_reg <= speed_clamped[kdd_pkg::SPEED_W-1:0];
                end
                kdd_pkg::KEY_INC:
                begin
                    if (speed_inc_reg < kdd_pkg::INC_MAX)
                    begin
                        speed_inc_reg <= speed_inc_reg + kdd_pkg::INC_W'(1);
                    end
                end
                kdd_pkg::KEY_DEC:
                begin
                    if (speed_inc_reg > kdd_pkg::INC_MIN)
                    begin
                        speed_inc_reg <= speed_inc_reg - kdd_pkg::INC_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kdd_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = kdd_pkg::ST_SWEEP;
                end
            end
            kdd_pkg::ST_SWEEP:
            begin
                if (last_step)
                begin
                    state_next = kdd_pkg::ST_MUL;
                end
            end
            kdd_pkg::ST_MUL:
            begin
                state_next = kdd_pkg::ST_SUM;
            end
            kdd_pkg::ST_SUM:
            begin
                if (sum_load)
                begin
                    state_next = kdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Advance the sweep, count active impulses, move the write slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            count_reg      <= '0;
            write_slot_reg <= '0;
        end
        else if (in_xfer)
        begin
            step_reg  <= '0;
            count_reg <= '0;
        end
        else if (shift)
        begin
            step_reg <= last_step ? '0 : step_reg + IW'(1);
            if (head_out.active)
            begin
                count_reg <= head_out.right ? count_reg + CW'(1) : count_reg - CW'(1);
            end
            if (last_step && head_ctrl.push)
            begin
                write_slot_reg <= (write_slot_reg == IW'(NUM_IMPULSES - 1)) ?
                                  '0 : write_slot_reg + IW'(1);
            end
        end
    end

    // Entry at the last cell on this step is slot NUM_IMPULSES-1-step
    assign cur_slot             = IW'(NUM_IMPULSES - 1) - step_reg;
    assign head_ctrl.stop       = (kcls_reg == kdd_pkg::KEY_STOP);
    assign head_ctrl.push       = (kcls_reg == kdd_pkg::KEY_LEFT) ||
                                  (kcls_reg == kdd_pkg::KEY_RIGHT);
    assign head_ctrl.push_right = (kcls_reg == kdd_pkg::KEY_RIGHT);
    assign head_ctrl.at_slot    = (cur_slot == write_slot_reg);

    kdd_head u_head (
        .entry_in  (cell_q[NUM_IMPULSES-1]),
        .elapsed   (elapsed_reg),
        .lifetime  (lifetime_reg),
        .ctrl      (head_ctrl),
        .entry_out (head_out)
    );

    // Ring of cells, first fed by the head, each next by its neighbor
    for (genvar j = 0; j < NUM_IMPULSES; j++)
    begin : g_cell
        if (j == 0)
        begin : g_first
            kdd_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (head_out),
                .q     (cell_q[j])
            );
        end
        else
        begin : g_rest
            kdd_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_q[j-1]),
                .q     (cell_q[j])
            );
        end
    end

    // Direction from the impulse count
    always_ff @(posedge clk)
    begin
        if (state_reg == kdd_pkg::ST_MUL)
        begin
            dir_reg <= DW'(count_reg) * DW'($signed({1'b0, turn_step_reg}));
        end
    end

    // Wheel sums and saturation
    always_comb
    begin
        out_max   = SW'(kdd_pkg::OUT_MAX);
        out_min   = -out_max;
        left_sum  = SW'(base_speed_reg) + SW'(dir_reg);
        right_sum = SW'(base_speed_reg) - SW'(dir_reg);
        if (left_sum > out_max)
        begin
            left_sat = out_max[kdd_pkg::SPEED_W-1:0];
        end
        else if (left_sum < out_min)
        begin
            left_sat = out_min[kdd_pkg::SPEED_W-1:0];
        end
        else
        begin
            left_sat = left_sum[kdd_pkg::SPEED_W-1:0];
        end
        if (right_sum > out_max)
        begin
            right_sat = out_max[kdd_pkg::SPEED_W-1:0];
        end
        else if (right_sum < out_min)
        begin
            right_sat = out_min[kdd_pkg::SPEED_W-1:0];
        end
        else
        begin
            right_sat = right_sum[kdd_pkg::SPEED_W-1:0];
        end
    end

    // Output valid: set on load, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sum_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (sum_load)
        begin
            left_reg    <= left_sat;
            right_reg   <= right_sat;
            unknown_reg <= (kcls_reg == kdd_pkg::KEY_BAD);
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign unknown_key = unknown_reg;

    // A speed step always lands within the limit in force at transfer
    a_speed_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (kcls_in == kdd_pkg::KEY_FWD || kcls_in == kdd_pkg::KEY_BACK)) |=>
        (BW'(base_speed_reg) <= $signed({{(BW - kdd_pkg::LIMIT_W){1'b0}},
                                          $past(speed_limit_reg)})) &&
        (BW'(base_speed_reg) >= -$signed({{(BW - kdd_pkg::LIMIT_W){1'b0}},
                                           $past(speed_limit_reg)})))
        else $error("base speed outside limit after speed step");

    // The ring has made exactly one full turn when the multiply starts
    a_sweep_wrapped : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kdd_pkg::ST_MUL) |-> (step_reg == '0))
        else $error("sweep counter not back at zero");

    // After stop no impulse may be counted
    a_stop_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kdd_pkg::ST_MUL && kcls_reg == kdd_pkg::KEY_STOP) |-> (count_reg == '0))
        else $error("impulses counted after stop");

endmodule

`default_nettype wire

>>> hw/rtl/kdd_cell.sv
// One storage cell of the turn impulse ring.
// Depends on kdd_pkg for the impulse entry type.
`default_nettype none

module kdd_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire kdd_pkg::impulse_t d,
    output kdd_pkg::impulse_t      q
);

    kdd_pkg::impulse_t entry_reg;

    // Take the neighbor's entry on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

>>> hw/rtl/kdd_head.sv
// Ring head: ages, expires, clears and writes the entry that leaves the
// last cell on its way back to the first. Depends on kdd_pkg.
`default_nettype none

module kdd_head (
    input  wire kdd_pkg::impulse_t               entry_in,
    input  wire logic [kdd_pkg::ELAPSED_W-1:0]   elapsed,
    input  wire logic [kdd_pkg::AGE_W-1:0]       lifetime,
    input  wire kdd_pkg::head_ctrl_t             ctrl,
    output kdd_pkg::impulse_t                    entry_out
);

    logic [kdd_pkg::AGE_W:0] age_sum;
    kdd_pkg::impulse_t       aged;

    assign age_sum = {1'b0, entry_in.age} + {{(kdd_pkg::AGE_W + 1 - kdd_pkg::ELAPSED_W){1'b0}},
                                              elapsed};

    // Age an active entry, drop it once past the lifetime
    always_comb
    begin
        aged = entry_in;
        if (entry_in.active)
        begin
            if (age_sum > {1'b0, lifetime})
            begin
                aged = '0;
            end
            else
            begin
                aged.age = age_sum[kdd_pkg::AGE_W-1:0];
            end
        end
    end

    // Apply the key: stop clears, a push writes a fresh impulse at the slot
    always_comb
    begin
        entry_out = aged;
        if (ctrl.stop)
        begin
            entry_out = '0;
        end
        else if (ctrl.push && ctrl.at_slot)
        begin
            entry_out.active = 1'b1;
            entry_out.right  = ctrl.push_right;
            entry_out.age    = kdd_pkg::AGE_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for keypad_differential_drive_command: drives key/elapsed transfers,
// predicts wheel speeds in a scoreboard class and checks every result transfer.
// Depends on kdd_pkg and the keypad_differential_drive_command RTL.

module testbench;

    localparam int RING_DEPTH  = kdd_pkg::NUM_IMPULSES_DEF;
    localparam int PHASE_ITEMS = 175;
    localparam int TAIL_CYCLES = 40;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [kdd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Predict wheel speeds per key transfer and compare result transfers in order
    class wheel_speed_board;
        int unsigned speed_limit;
        int unsigned turn_step;
        int unsigned lifetime;
        int          base_speed;
        int          speed_step;
        int          write_slot;
        bit          imp_active [RING_DEPTH];
        bit          imp_right  [RING_DEPTH];
        int unsigned imp_age    [RING_DEPTH];

        logic signed [kdd_pkg::SPEED_W-1:0] exp_left_speed  [$];
        logic signed [kdd_pkg::SPEED_W-1:0] exp_right_speed [$];
        logic                               exp_unknown_key [$];
        int                                 mismatches;

        function new();
            speed_limit = int'(kdd_pkg::SPEED_LIMIT_RST);
            turn_step   = int'(kdd_pkg::TURN_STEP_RST);
            lifetime    = int'(kdd_pkg::LIFETIME_RST);
            base_speed  = 0;
            speed_step  = int'(kdd_pkg::INC_RST);
            write_slot  = 0;
            mismatches  = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                imp_active[i] = 1'b0;
                imp_right[i]  = 1'b0;
                imp_age[i]    = 0;
            end
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void push_impulse(bit to_right);
            imp_active[write_slot] = 1'b1;
            imp_right[write_slot]  = to_right;
            imp_age[write_slot]    = 1;
            write_slot = (write_slot + 1) % RING_DEPTH;
        endfunction

        function void note_setting(logic [kdd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [kdd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                kdd_pkg::CFG_SPEED_LIMIT: speed_limit = int'(data[kdd_pkg::LIMIT_W-1:0]);
                kdd_pkg::CFG_TURN_STEP:   turn_step   = int'(data[kdd_pkg::TURN_W-1:0]);
                kdd_pkg::CFG_LIFETIME:    lifetime    = int'(data[kdd_pkg::AGE_W-1:0]);
                default:                  ;
            endcase
        endfunction

        function void note_key(logic [kdd_pkg::KEY_W-1:0] key,
                               logic [kdd_pkg::ELAPSED_W-1:0] dt);
            int          lim;
            int          count;
            int          dir;
            bit          unknown;
            int unsigned aged;
            lim     = int'(speed_limit);
            count   = 0;
            unknown = 1'b0;

            // Age active impulses, drop the ones past their lifetime
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                if (imp_active[i])
                begin
                    aged = imp_age[i] + 32'(dt);
                    if (aged > lifetime)
                    begin
                        imp_active[i] = 1'b0;
                        imp_right[i]  = 1'b0;
                        imp_age[i]    = 0;
                    end
                    else
                        imp_age[i] = aged;
                end
            end

            // Apply the key
            case (key)
                kdd_pkg::KEY_CODE_S, kdd_pkg::KEY_CODE_5:
                begin
                    base_speed = 0;
                    clear_ring();
                end
                kdd_pkg::KEY_CODE_W, kdd_pkg::KEY_CODE_8:
                    base_speed = clamp(base_speed + speed_step, -lim, lim);
                kdd_pkg::KEY_CODE_X, kdd_pkg::KEY_CODE_2:
                    base_speed = clamp(base_speed - speed_step, -lim, lim);
                kdd_pkg::KEY_CODE_A, kdd_pkg::KEY_CODE_4: push_impulse(1'b0);
                kdd_pkg::KEY_CODE_D, kdd_pkg::KEY_CODE_6: push_impulse(1'b1);
                kdd_pkg::KEY_CODE_PLUS:
                    if (speed_step < int'(kdd_pkg::INC_MAX))
                        speed_step++;
                kdd_pkg::KEY_CODE_MINUS:
                    if (speed_step > int'(kdd_pkg::INC_MIN))
                        speed_step--;
                kdd_pkg::KEY_CODE_Q, kdd_pkg::KEY_CODE_7, kdd_pkg::KEY_CODE_Y,
                kdd_pkg::KEY_CODE_1, kdd_pkg::KEY_CODE_E, kdd_pkg::KEY_CODE_9,
                kdd_pkg::KEY_CODE_C, kdd_pkg::KEY_CODE_3,
                kdd_pkg::KEY_CODE_NONE: ;
                default: unknown = 1'b1;
            endcase

            // Count right minus left impulses and form both wheel speeds
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                if (imp_active[i])
                    count += imp_right[i] ? 1 : -1;
            end
            dir = count * int'(turn_step);
            exp_left_speed.push_back(kdd_pkg::SPEED_W'(
                clamp(base_speed + dir, -kdd_pkg::OUT_MAX, kdd_pkg::OUT_MAX)));
            exp_right_speed.push_back(kdd_pkg::SPEED_W'(
                clamp(base_speed - dir, -kdd_pkg::OUT_MAX, kdd_pkg::OUT_MAX)));
            exp_unknown_key.push_back(unknown);
        endfunction

        function void check_speeds(logic signed [kdd_pkg::SPEED_W-1:0] l,
                                   logic signed [kdd_pkg::SPEED_W-1:0] r,
                                   logic u);
            logic signed [kdd_pkg::SPEED_W-1:0] want_l;
            logic signed [kdd_pkg::SPEED_W-1:0] want_r;
            logic                               want_u;
            if (exp_left_speed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: left %0d right %0d unknown %0b", l, r, u);
                return;
            end
            want_l = exp_left_speed.pop_front();
            want_r = exp_right_speed.pop_front();
            want_u = exp_unknown_key.pop_front();
            if (l !== want_l || r !== want_r || u !== want_u)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"speed mismatch: left %0d (exp %0d) right %0d (exp %0d)",
                              " unknown %0b (exp %0b)"},
                             l, want_l, r, want_r, u, want_u);
            end
        endfunction

        function int pending();
            return exp_left_speed.size();
        endfunction
    endclass

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                cfg_valid   = 1'b0;
    wire                                 cfg_ready;
    logic [kdd_pkg::CFG_IDX_W-1:0]       cfg_index   = kdd_pkg::CFG_SPEED_LIMIT;
    logic [kdd_pkg::CFG_DATA_W-1:0]      cfg_data    = '0;
    logic                                in_valid    = 1'b0;
    wire                                 in_ready;
    logic [kdd_pkg::KEY_W-1:0]           operation   = kdd_pkg::KEY_CODE_NONE;
    logic [kdd_pkg::ELAPSED_W-1:0]       elapsed     = '0;
    wire                                 out_valid;
    logic                                out_ready   = 1'b0;
    wire signed [kdd_pkg::SPEED_W-1:0]   left_speed;
    wire signed [kdd_pkg::SPEED_W-1:0]   right_speed;
    wire                                 unknown_key;

    wheel_speed_board board;
    int rx_cycle = 0;
    int rx_mode  = 0;

    keypad_differential_drive_command #(
        .NUM_IMPULSES(RING_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .elapsed    (elapsed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .left_speed (left_speed),
        .right_speed(right_speed),
        .unknown_key(unknown_key)
    );

    // Free-running clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("[keypad_differential_drive_command] ERROR");
        $finish;
    end

    // Check result transfers; stall the receiver by windows of changing patterns
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_speeds(left_speed, right_speed, unknown_key);
        if (rx_cycle % 48 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cycle = rx_cycle + 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (rx_cycle % 5 == 0);
            default: out_ready <= (rx_cycle % 7 < 4);
        endcase
    end

    // Hold one key transfer until accepted, then record it
    task automatic send_item(input logic [kdd_pkg::KEY_W-1:0] key,
                             input logic [kdd_pkg::ELAPSED_W-1:0] dt);
        in_valid  <= 1'b1;
        operation <= key;
        elapsed   <= dt;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_key(key, dt);
    endtask

    // Hold one register write until accepted; caller drops cfg_valid afterwards
    task automatic write_register(input logic [kdd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [kdd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.note_setting(idx, data);
    endtask

    // Write all three registers, junk above the limit and turn fields; optional stray write
    task automatic apply_settings(input logic [kdd_pkg::LIMIT_W-1:0] limit,
                                  input logic [kdd_pkg::TURN_W-1:0] turn,
                                  input logic [kdd_pkg::AGE_W-1:0] life, input bit stray);
        logic [kdd_pkg::CFG_DATA_W-1:0] junk;
        junk = kdd_pkg::CFG_DATA_W'($urandom);
        write_register(kdd_pkg::CFG_SPEED_LIMIT,
                       {junk[kdd_pkg::CFG_DATA_W-1:kdd_pkg::LIMIT_W], limit});
        write_register(kdd_pkg::CFG_TURN_STEP,
                       {junk[kdd_pkg::CFG_DATA_W-1:kdd_pkg::TURN_W], turn});
        write_register(kdd_pkg::CFG_LIFETIME, life);
        if (stray)
            write_register(CFG_UNUSED, junk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every expected result has been transferred
    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Weighted key choice: mostly commands, some idle keys and random codes
    function automatic logic [kdd_pkg::KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return $urandom_range(0, 1) ? kdd_pkg::KEY_CODE_W : kdd_pkg::KEY_CODE_8;
        if (sel < 27)
            return $urandom_range(0, 1) ? kdd_pkg::KEY_CODE_X : kdd_pkg::KEY_CODE_2;
        if (sel < 42)
            return $urandom_range(0, 1) ? kdd_pkg::KEY_CODE_A : kdd_pkg::KEY_CODE_4;
        if (sel < 57)
            return $urandom_range(0, 1) ? kdd_pkg::KEY_CODE_D : kdd_pkg::KEY_CODE_6;
        if (sel < 61)
            return $urandom_range(0, 1) ? kdd_pkg::KEY_CODE_S : kdd_pkg::KEY_CODE_5;
        if (sel < 71)
            return $urandom_range(0, 1) ? kdd_pkg::KEY_CODE_PLUS : kdd_pkg::KEY_CODE_MINUS;
        if (sel < 79)
            return kdd_pkg::KEY_CODE_NONE;
        if (sel < 85)
        begin
            case ($urandom_range(0, 7))
                0:       return kdd_pkg::KEY_CODE_Q;
                1:       return kdd_pkg::KEY_CODE_7;
                2:       return kdd_pkg::KEY_CODE_Y;
                3:       return kdd_pkg::KEY_CODE_1;
                4:       return kdd_pkg::KEY_CODE_E;
                5:       return kdd_pkg::KEY_CODE_9;
                6:       return kdd_pkg::KEY_CODE_C;
                default: return kdd_pkg::KEY_CODE_3;
            endcase
        end
        return kdd_pkg::KEY_W'($urandom_range(0, 255));
    endfunction

    // Elapsed time mostly scaled to the lifetime so impulses live a few items
    function automatic logic [kdd_pkg::ELAPSED_W-1:0] pick_elapsed(input int unsigned life);
        int          sel;
        int unsigned bound;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel <= 4)
            return kdd_pkg::ELAPSED_W'($urandom);
        bound = life / 8 + 1;
        if (bound > 32'hFFFFF)
            bound = 32'hFFFFF;
        return kdd_pkg::ELAPSED_W'($urandom_range(0, bound));
    endfunction

    // Random key transfers in bursts separated by random gaps
    task automatic run_phase(input int count);
        int burst;
        int gap;
        burst = 0;
        repeat (count)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_item(pick_key(), pick_elapsed(board.lifetime));
            burst--;
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys under reset settings: every command, idle and unknown codes
        send_item(kdd_pkg::KEY_CODE_NONE, '0);
        send_item(kdd_pkg::KEY_CODE_W, '0);
        send_item(kdd_pkg::KEY_CODE_X, 20'd5);
        send_item(kdd_pkg::KEY_CODE_PLUS, '0);
        send_item(kdd_pkg::KEY_CODE_2, '0);
        send_item(kdd_pkg::KEY_CODE_MINUS, '0);
        send_item(kdd_pkg::KEY_CODE_A, 20'd1);
        send_item(kdd_pkg::KEY_CODE_4, 20'd100);
        send_item(kdd_pkg::KEY_CODE_D, 20'd999998);
        send_item(kdd_pkg::KEY_CODE_6, '0);
        send_item(kdd_pkg::KEY_CODE_NONE, 20'd1);
        send_item(kdd_pkg::KEY_CODE_Q, 20'd3);
        send_item(kdd_pkg::KEY_CODE_7, '0);
        send_item(kdd_pkg::KEY_CODE_E, '0);
        send_item(kdd_pkg::KEY_CODE_3, '0);
        send_item(8'hFF, '0);
        send_item(8'h7A, '1);
        send_item(kdd_pkg::KEY_CODE_5, '0);
        send_item(kdd_pkg::KEY_CODE_S, 20'd2);
        send_item(kdd_pkg::KEY_CODE_8, '0);
        send_item(kdd_pkg::KEY_CODE_8, '0);
        in_valid <= 1'b0;
        wait_drained();

        // Lower the limit under the current speed, zero lifetime, widest turn step
        apply_settings(16'd15, 12'd4095, 21'd0, 1'b0);
        send_item(kdd_pkg::KEY_CODE_A, '0);
        send_item(kdd_pkg::KEY_CODE_D, '0);
        send_item(kdd_pkg::KEY_CODE_W, '0);
        send_item(kdd_pkg::KEY_CODE_X, 20'd7);
        send_item(kdd_pkg::KEY_CODE_X, '0);
        send_item(kdd_pkg::KEY_CODE_2, '0);
        in_valid <= 1'b0;
        wait_drained();

        // Random phases over extreme, default and random settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_settings(16'hFFFF, 12'hFFF, 21'h1FFFFF, 1'b0);
                1: apply_settings(16'd0, 12'd0, 21'd1, 1'b0);
                2: apply_settings(kdd_pkg::SPEED_LIMIT_RST, kdd_pkg::TURN_STEP_RST,
                                  kdd_pkg::LIFETIME_RST, 1'b1);
                3: apply_settings(kdd_pkg::LIMIT_W'($urandom_range(0, 300)),
                                  kdd_pkg::TURN_W'($urandom),
                                  kdd_pkg::AGE_W'($urandom_range(1, 5000)), 1'b0);
                default: apply_settings(kdd_pkg::LIMIT_W'($urandom), kdd_pkg::TURN_W'($urandom),
                                        kdd_pkg::AGE_W'($urandom_range(1, 2097151)), 1'b1);
            endcase
            run_phase(PHASE_ITEMS);
            in_valid <= 1'b0;
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[keypad_differential_drive_command] OK");
        else
            $display("[keypad_differential_drive_command] ERROR");
        $finish;
    end

endmodule
